/* rtl/core/stack_machine_executor_defines.svh */
// ---------------------------------------------------------------------------
// Stack machine executor assertion macros
// Shared macros for the concurrent checks of the executor.
// ---------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define SME_ASSERT_IMP(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define SME_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/core/sme_pkg.sv */
// ---------------------------------------------------------------------------
// Stack machine executor package
// Shared constants and types for the executor.
// ---------------------------------------------------------------------------
package sme_pkg;
    localparam int VAL_W       = 31;
    localparam int LIMIT_W     = 30;
    localparam int KIND_W      = 4;
    localparam int DEF_DEPTH   = 1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd1000000000;

    typedef enum logic [KIND_W-1:0] {
        K_START = 4'd0, K_NUM = 4'd1, K_POP = 4'd2, K_INV = 4'd3,
        K_DUP = 4'd4, K_SWP = 4'd5, K_ADD = 4'd6, K_SUB = 4'd7,
        K_MUL = 4'd8, K_DIV = 4'd9, K_MOD = 4'd10, K_END = 4'd11
    } kind_t;

    typedef struct packed {
        logic             start;
        logic             is_mod;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } div_req_t;
endpackage

/* rtl/core/sme_ram.sv */
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/core/sme_div.sv */
// ---------------------------------------------------------------------------
// Stack machine executor divider
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module sme_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  sme_pkg::div_req_t  req,
    output logic               done,
    output logic [sme_pkg::VAL_W-1:0] result
);
    import sme_pkg::*;

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] dsr_reg, dsr_next;
    logic             qneg_reg, qneg_next, rneg_reg, rneg_next, mod_reg, mod_next;
    logic             done_reg, done_next;
    logic [VAL_W:0]   trial;
    logic [VAL_W-1:0] shifted, q_out, r_out;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        mod_next  = mod_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[VAL_W-2:0], quo_reg[VAL_W-1]};
        trial     = {1'b0, shifted} - {1'b0, dsr_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VAL_W);
            quo_next  = req.dividend[VAL_W-1] ? -req.dividend : req.dividend;
            dsr_next  = req.divisor[VAL_W-1] ? -req.divisor : req.divisor;
            rem_next  = '0;
            qneg_next = req.dividend[VAL_W-1] ^ req.divisor[VAL_W-1];
            rneg_next = req.dividend[VAL_W-1];
            mod_next  = req.is_mod;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VAL_W-2:0], ~trial[VAL_W]};
            rem_next = trial[VAL_W] ? shifted : trial[VAL_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
        mod_reg  <= mod_next;
    end

    assign q_out  = qneg_reg ? -quo_reg : quo_reg;
    assign r_out  = rneg_reg ? -rem_reg : rem_reg;
    assign done   = done_reg;
    assign result = mod_reg ? r_out : q_out;
endmodule

/* rtl/core/stack_machine_executor.sv */
// ---------------------------------------------------------------------------
// Stack machine executor
// Runs a stack machine one instruction word at a time on a RAM-based stack.
// ---------------------------------------------------------------------------
// Instruction words arrive on the s_axis channel: tuser holds the kind and
// tdata the operand. Only END produces a word on the m_axis channel, with
// the result value in tdata and the error flag in tuser.
// The block takes one instruction at a time. Start, NUM, POP, unused kinds
// and words ignored after a fault finish in S_IDLE. INV and DUP pass through
// S_RD2, END through S_OUT, and SWP through S_RD1, S_RD2, S_EXEC and S_WR2,
// as the stack RAM has registered read data. Binary operations take the SWP
// path plus S_DIV, where DIV and MOD wait for the one-bit-per-cycle
// divider. SWP and binary operations read two entries through the single
// RAM port, one per cycle. The END result is read in S_OUT and waits in an
// output register; while the receiver stalls, the next instruction is still
// taken and executed, and only a second END waits until the first is gone.
// After reset the stack is empty, the fault flag is clear and the magnitude
// limit is 1000000000. The stack RAM needs no clearing pass.
// The magnitude limit is written through the APB port at address 0.
// ---------------------------------------------------------------------------
module stack_machine_executor #(
    parameter int STACK_DEPTH = sme_pkg::DEF_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] operand
    input  logic [3:0]  s_axis_tuser,   // [3:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] result_value
    output logic        m_axis_tuser,   // [0] is_error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sme_pkg::*;
    `include "stack_machine_executor_defines.svh"

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_RD1 = 7'b0000010, S_RD2 = 7'b0000100,
        S_EXEC = 7'b0001000, S_DIV = 7'b0010000, S_WR2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t               st_reg, st_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 fault_reg, fault_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [VAL_W-1:0]     x_reg, x_next, y_reg, y_next, w2_reg, w2_next;
    logic                 ov_reg, ov_next;
    logic                 mv_reg, mv_next, me_reg, me_next;
    logic [VAL_W-1:0]     mval_reg, mval_next;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [VAL_W-1:0]     ram_wdata, ram_rdata, div_res;
    div_req_t             dreq;
    logic                 div_done;
    logic [2*VAL_W-1:0]   prod;
    logic signed [VAL_W+1:0] sum;
    logic [VAL_W+1:0]     mag;
    logic [2*VAL_W-1:0]   pmag;
    logic                 accept, wr_cfg;
    logic [KIND_W-1:0]    in_kind;
    logic [VAL_W-1:0]     in_opnd;

    sme_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    sme_div u_div (
        .aclk(aclk), .aresetn(aresetn), .req(dreq), .done(div_done), .result(div_res)
    );

    assign in_kind = s_axis_tuser;
    assign in_opnd = s_axis_tdata[VAL_W-1:0];
    assign s_axis_tready = (st_reg == S_IDLE) &&
        !(mv_reg && !m_axis_tready && in_kind == K_END);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign wr_cfg = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {{(32-LIMIT_W){1'b0}}, limit_reg} : 32'd0;
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = {{(32-VAL_W){1'b0}}, mval_reg};
    assign m_axis_tuser  = me_reg;

    assign prod = (2*VAL_W)'($signed(y_reg)) * (2*VAL_W)'($signed(x_reg));

    always_comb begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        fault_next = fault_reg;
        kind_next  = kind_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        w2_next    = w2_reg;
        ov_next    = ov_reg;
        mv_next    = mv_reg && !m_axis_tready;
        me_next    = me_reg;
        mval_next  = mval_reg;
        ram_we     = 1'b0;
        ram_addr   = cnt_reg[AW-1:0] - 1'b1;
        ram_wdata  = x_reg;
        dreq       = '0;
        sum        = '0;
        mag        = '0;
        pmag       = '0;
        unique case (st_reg)
            S_IDLE: begin
                if (accept) begin
                    kind_next = in_kind;
                    x_next    = in_opnd;
                    if (in_kind == K_START) begin
                        ram_we     = 1'b1;
                        ram_addr   = '0;
                        ram_wdata  = in_opnd;
                        cnt_next   = CW'(1);
                        fault_next = 1'b0;
                    end else if (in_kind == K_END) begin
                        ram_addr   = '0;
                        me_next    = fault_reg || cnt_reg != CW'(1);
                        st_next    = S_OUT;
                    end else if (in_kind > K_END || fault_reg) begin
                        st_next = S_IDLE;
                    end else if (in_kind == K_NUM) begin
                        if (cnt_reg == CW'(STACK_DEPTH)) begin
                            fault_next = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            ram_addr  = cnt_reg[AW-1:0];
                            ram_wdata = in_opnd;
                            cnt_next  = cnt_reg + 1'b1;
                        end
                    end else if (in_kind == K_POP) begin
                        if (cnt_reg == '0) fault_next = 1'b1;
                        else cnt_next = cnt_reg - 1'b1;
                    end else if (in_kind == K_INV || in_kind == K_DUP) begin
                        if (cnt_reg == '0) fault_next = 1'b1;
                        else if (in_kind == K_DUP && cnt_reg == CW'(STACK_DEPTH))
                            fault_next = 1'b1;
                        else st_next = S_RD2;
                    end else begin
                        if (cnt_reg < CW'(2)) fault_next = 1'b1;
                        else st_next = S_RD1;
                    end
                end
            end
            S_RD1: begin
                x_next   = ram_rdata;
                ram_addr = cnt_reg[AW-1:0] - AW'(2);
                st_next  = S_RD2;
            end
            S_RD2: begin
                if (kind_reg == K_INV) begin
                    ram_we    = 1'b1;
                    ram_wdata = -ram_rdata;
                    st_next   = S_IDLE;
                end else if (kind_reg == K_DUP) begin
                    ram_we    = 1'b1;
                    ram_addr  = cnt_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    cnt_next  = cnt_reg + 1'b1;
                    st_next   = S_IDLE;
                end else begin
                    ram_addr = cnt_reg[AW-1:0] - AW'(2);
                    st_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                // x_reg holds the top, ram_rdata the entry below it.
                y_next = ram_rdata;
                if (kind_reg == K_SWP) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    w2_next   = x_reg;
                    st_next   = S_WR2;
                end else if (kind_reg == K_DIV || kind_reg == K_MOD) begin
                    if (x_reg == '0) begin
                        fault_next = 1'b1;
                        st_next    = S_IDLE;
                    end else begin
                        dreq.start    = 1'b1;
                        dreq.is_mod   = kind_reg == K_MOD;
                        dreq.dividend = ram_rdata;
                        dreq.divisor  = x_reg;
                        st_next       = S_DIV;
                    end
                end else begin
                    st_next = S_DIV;
                end
            end
            S_DIV: begin
                if (kind_reg == K_ADD || kind_reg == K_SUB || kind_reg == K_MUL) begin
                    if (kind_reg == K_MUL) begin
                        pmag = prod[2*VAL_W-1] ? -prod : prod;
                        ov_next = pmag > (2*VAL_W)'(limit_reg);
                        w2_next = prod[VAL_W-1:0];
                    end else begin
                        sum = (kind_reg == K_ADD)
                            ? $signed({{2{y_reg[VAL_W-1]}}, y_reg})
                              + $signed({{2{x_reg[VAL_W-1]}}, x_reg})
                            : $signed({{2{y_reg[VAL_W-1]}}, y_reg})
                              - $signed({{2{x_reg[VAL_W-1]}}, x_reg});
                        mag = sum[VAL_W+1] ? -sum : sum;
                        ov_next = mag > (VAL_W+2)'(limit_reg);
                        w2_next = sum[VAL_W-1:0];
                    end
                    kind_next = K_END;
                    st_next   = S_WR2;
                end else if (div_done) begin
                    w2_next   = div_res;
                    ov_next   = 1'b0;
                    kind_next = K_END;
                    st_next   = S_WR2;
                end
            end
            S_WR2: begin
                if (kind_reg == K_SWP) begin
                    ram_we    = 1'b1;
                    ram_addr  = cnt_reg[AW-1:0] - AW'(2);
                    ram_wdata = w2_reg;
                end else if (ov_reg) begin
                    fault_next = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_addr  = cnt_reg[AW-1:0] - AW'(2);
                    ram_wdata = w2_reg;
                    cnt_next  = cnt_reg - 1'b1;
                end
                st_next = S_IDLE;
            end
            S_OUT: begin
                mval_next  = me_reg ? '0 : ram_rdata;
                mv_next    = 1'b1;
                cnt_next   = '0;
                fault_next = 1'b0;
                st_next    = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            cnt_reg   <= '0;
            fault_reg <= 1'b0;
            mv_reg    <= 1'b0;
            limit_reg <= LIMIT_RESET;
        end else begin
            st_reg    <= st_next;
            cnt_reg   <= cnt_next;
            fault_reg <= fault_next;
            mv_reg    <= mv_next;
            if (wr_cfg && paddr == 2'd0) limit_reg <= pwdata[LIMIT_W-1:0];
        end
        kind_reg <= kind_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        w2_reg   <= w2_next;
        ov_reg   <= ov_next;
        me_reg   <= me_next;
        mval_reg <= mval_next;
    end

    `SME_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= CW'(STACK_DEPTH),
        "stack count beyond depth")
    `SME_ASSERT_NEXT(a_out_clears, aclk, aresetn, st_reg == S_OUT,
        cnt_reg == '0 && !fault_reg && m_axis_tvalid, "END did not clear the machine")
    `SME_ASSERT_IMP(a_err_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata == 32'd0, "error result carries a value")
endmodule
